### rtl/ctbc_pkg.sv
package ctbc_pkg;

  // Field widths
  localparam int unsigned SEC_W   = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned EV_W    = 3;
  localparam int unsigned TMO_W   = 7;
  localparam int unsigned HOLD_W  = 6;
  localparam int unsigned GUARD_W = 3;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned PRESET_SLOTS_DEF = 10;

  // Configuration reset values
  localparam logic [SEC_W-1:0]   MAX_SECONDS_RST   = 16'd35999;
  localparam logic [TMO_W-1:0]   TIMEOUT_LIMIT_RST = 7'd100;
  localparam logic [TMO_W-1:0]   ALARM_HOLD_RST    = 7'd40;
  localparam logic [HOLD_W-1:0]  LONG_TICKS_RST    = 6'd32;
  localparam logic [HOLD_W-1:0]  REPEAT_TICKS_RST  = 6'd9;
  localparam logic [GUARD_W-1:0] WAKE_GUARD_RST    = 3'd7;

  localparam logic [TMO_W-1:0] TMO_TOP = 7'h7F;

  // Adjust step sizes
  localparam int unsigned ADJ_W = 13;
  localparam logic signed [ADJ_W-1:0] STEP_1S  = 13'sd1;
  localparam logic signed [ADJ_W-1:0] STEP_10S = 13'sd10;
  localparam logic signed [ADJ_W-1:0] STEP_1M  = 13'sd60;
  localparam logic signed [ADJ_W-1:0] STEP_10M = 13'sd600;
  localparam logic signed [ADJ_W-1:0] STEP_1H  = 13'sd3600;

  typedef enum logic [OP_W-1:0] {
    OP_POLL = 2'd0,
    OP_SLOW = 2'd1,
    OP_SEC  = 2'd2,
    OP_WAKE = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SECONDS   = 3'd0,
    CFG_TIMEOUT_LIMIT = 3'd1,
    CFG_ALARM_HOLD    = 3'd2,
    CFG_LONG_TICKS    = 3'd3,
    CFG_REPEAT_TICKS  = 3'd4,
    CFG_WAKE_GUARD    = 3'd5
  } cfg_idx_e;

  typedef enum logic [8:0] {
    MODE_INIT  = 9'b0_0000_0001,
    MODE_COUNT = 9'b0_0000_0010,
    MODE_WAIT  = 9'b0_0000_0100,
    MODE_ADJS  = 9'b0_0000_1000,
    MODE_ADJM  = 9'b0_0001_0000,
    MODE_ADJH  = 9'b0_0010_0000,
    MODE_ALARM = 9'b0_0100_0000,
    MODE_SAVE  = 9'b0_1000_0000,
    MODE_DOWN  = 9'b1_0000_0000
  } mode_e;

  typedef enum logic [EV_W-1:0] {
    EV_LEFT    = 3'd0,
    EV_RIGHT   = 3'd1,
    EV_BOTH    = 3'd2,
    EV_LLEFT   = 3'd3,
    EV_LRIGHT  = 3'd4,
    EV_TIMEOUT = 3'd5,
    EV_NONE    = 3'd6
  } ev_e;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_SHORT = 2'd1,
    BTN_LONG  = 2'd2
  } btn_e;

  typedef struct packed {
    logic [HOLD_W-1:0] long_ticks;
    logic [HOLD_W-1:0] repeat_ticks;
  } btn_cfg_t;

  // External mode code of a one-hot state
  function automatic logic [MODE_W-1:0] mode_code(mode_e m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MODE_INIT:  c = 4'd0;
      MODE_COUNT: c = 4'd1;
      MODE_WAIT:  c = 4'd2;
      MODE_ADJS:  c = 4'd3;
      MODE_ADJM:  c = 4'd4;
      MODE_ADJH:  c = 4'd5;
      MODE_ALARM: c = 4'd6;
      MODE_SAVE:  c = 4'd7;
      MODE_DOWN:  c = 4'd8;
      default:    c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/ctbc_if.sv
interface ctbc_in_if import ctbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic              left_level;
  logic              right_level;

  modport source (output valid, opcode, left_level, right_level, input ready);
  modport sink   (input valid, opcode, left_level, right_level, output ready);
endinterface

interface ctbc_out_if import ctbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SEC_W-1:0]  seconds_left;
  logic [SLOT_W-1:0] preset_index;
  logic [EV_W-1:0]   event_code;
  logic              alarm_started;
  logic              preset_written;
  logic              sleep_request;

  modport source (output valid, mode, seconds_left, preset_index, event_code,
                  alarm_started, preset_written, sleep_request, input ready);
  modport sink   (input valid, mode, seconds_left, preset_index, event_code,
                  alarm_started, preset_written, sleep_request, output ready);
endinterface

interface ctbc_cfg_if import ctbc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/countdown_timer_button_controller.sv
// Mode controller for a two-button countdown timer. Each input transfer is one
// item: a poll tick with both button pin levels (0 = pressed), a slow tick, a
// second-elapsed tick or a wake event. Every item yields exactly one result
// transfer carrying the mode, the seconds value, the preset slot, the event
// that drove the mode table and three strobes (alarm entered, preset stored,
// power down entered). One item is accepted per clock; its result is
// presented in the output register on the following cycle. The whole
// next-state function (press sorting, mode table, one bounded adjust add) is
// a single combinational pass from the state registers, so throughput is one
// item per cycle as long as the sink takes results. The output register
// decouples the sides: a new item is taken while the sink is ready or the
// register is empty. Configuration writes are always accepted (ready tied
// high) and take effect on the next item; indexes past the register list are
// dropped. The preset store lives in flip-flops and is cleared by reset.
module countdown_timer_button_controller import ctbc_pkg::*; #(
  parameter int unsigned PRESET_SLOTS = PRESET_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctbc_in_if.sink    in_ch,
  ctbc_out_if.source out_ch,
  ctbc_cfg_if.sink   cfg_ch
);

  localparam int unsigned IDX_W = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
  localparam logic [SLOT_W:0] SLOTS_N = (SLOT_W+1)'(PRESET_SLOTS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SEC_W-1:0]   max_sec_q;
  logic [TMO_W-1:0]   tmo_limit_q, alarm_hold_q;
  logic [HOLD_W-1:0]  long_ticks_q, repeat_ticks_q;
  logic [GUARD_W-1:0] wake_ticks_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sec_q      <= MAX_SECONDS_RST;
      tmo_limit_q    <= TIMEOUT_LIMIT_RST;
      alarm_hold_q   <= ALARM_HOLD_RST;
      long_ticks_q   <= LONG_TICKS_RST;
      repeat_ticks_q <= REPEAT_TICKS_RST;
      wake_ticks_q   <= WAKE_GUARD_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MAX_SECONDS:   max_sec_q      <= cfg_ch.data[SEC_W-1:0];
        CFG_TIMEOUT_LIMIT: tmo_limit_q    <= cfg_ch.data[TMO_W-1:0];
        CFG_ALARM_HOLD:    alarm_hold_q   <= cfg_ch.data[TMO_W-1:0];
        CFG_LONG_TICKS:    long_ticks_q   <= cfg_ch.data[HOLD_W-1:0];
        CFG_REPEAT_TICKS:  repeat_ticks_q <= cfg_ch.data[HOLD_W-1:0];
        CFG_WAKE_GUARD:    wake_ticks_q   <= cfg_ch.data[GUARD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  mode_e              mode_q, mode_d;
  logic [SEC_W-1:0]   sec_q, sec_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [HOLD_W-1:0]  lhold_q, lhold_d, rhold_q, rhold_d;
  logic [TMO_W-1:0]   tmo_q, tmo_d;
  logic [GUARD_W-1:0] guard_q, guard_d;
  logic [SEC_W-1:0]   store_q [PRESET_SLOTS];

  // Handshake: output register frees up when the sink takes it
  logic out_valid_q;
  logic in_ready, accept;

  assign in_ready    = !out_valid_q || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  op_e op;
  assign op = op_e'(in_ch.opcode);

  // ---------------------------------------------------------------------------
  // Button sampling
  // ---------------------------------------------------------------------------
  btn_cfg_t btn_cfg;
  btn_e     press_l, press_r_raw, press_r;
  logic [HOLD_W-1:0] lhold_n, rhold_n;

  assign btn_cfg.long_ticks   = long_ticks_q;
  assign btn_cfg.repeat_ticks = repeat_ticks_q;

  ctbc_button u_btn_left (
    .level_i (in_ch.left_level),
    .hold_i  (lhold_q),
    .cfg_i   (btn_cfg),
    .press_o (press_l),
    .hold_o  (lhold_n)
  );

  ctbc_button u_btn_right (
    .level_i (in_ch.right_level),
    .hold_i  (rhold_q),
    .cfg_i   (btn_cfg),
    .press_o (press_r_raw),
    .hold_o  (rhold_n)
  );

  // right button is not looked at during alarm
  assign press_r = (mode_q == MODE_ALARM) ? BTN_NONE : press_r_raw;

  function automatic ev_e sort_event(btn_e a, btn_e b);
    ev_e e;
    if (a == BTN_SHORT && b == BTN_SHORT)     e = EV_BOTH;
    else if (a == BTN_LONG && b == BTN_LONG)  e = EV_BOTH;
    else if (a == BTN_LONG)                   e = EV_LLEFT;
    else if (b == BTN_LONG)                   e = EV_LRIGHT;
    else if (a == BTN_SHORT)                  e = EV_LEFT;
    else if (b == BTN_SHORT)                  e = EV_RIGHT;
    else                                      e = EV_NONE;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Poll tick event
  // ---------------------------------------------------------------------------
  logic poll_live, tmo_fire, sample, counting, alarm_go, any_press;
  ev_e  ev;

  assign poll_live = (op == OP_POLL) && (mode_q != MODE_DOWN) && (guard_q == '0);
  assign tmo_fire  = poll_live && (tmo_q > tmo_limit_q);
  assign sample    = poll_live && !tmo_fire;
  assign counting  = (mode_q == MODE_COUNT) || (mode_q == MODE_SAVE);
  assign alarm_go  = sample && counting && (sec_q == '0);
  assign any_press = (press_l != BTN_NONE) || (press_r != BTN_NONE);

  always_comb begin
    if (tmo_fire)                           ev = EV_TIMEOUT;
    else if (sample && !alarm_go && any_press) ev = sort_event(press_l, press_r);
    else                                    ev = EV_NONE;
  end

  // ---------------------------------------------------------------------------
  // Preset read: one address, chosen by what the mode table will load
  // ---------------------------------------------------------------------------
  logic [SLOT_W:0]   slot_inc;
  logic [SLOT_W-1:0] slot_next, load_slot;
  logic [IDX_W-1:0]  cur_idx, load_idx;
  logic [SEC_W-1:0]  preset_rd;

  assign slot_inc  = {1'b0, slot_q} + (SLOT_W+1)'(1);
  assign slot_next = (slot_inc >= SLOTS_N) ? '0 : slot_inc[SLOT_W-1:0];

  always_comb begin
    load_slot = slot_q;
    if (mode_q == MODE_INIT && ev == EV_RIGHT)  load_slot = slot_next;
    if (mode_q == MODE_INIT && ev == EV_LLEFT)  load_slot = '0;
  end

  assign cur_idx   = ({1'b0, slot_q} < SLOTS_N) ? slot_q[IDX_W-1:0] : '0;
  assign load_idx  = ({1'b0, load_slot} < SLOTS_N) ? load_slot[IDX_W-1:0] : '0;
  assign preset_rd = store_q[load_idx];

  // ---------------------------------------------------------------------------
  // Adjust step: one signed add and a bounds check
  // ---------------------------------------------------------------------------
  logic signed [ADJ_W-1:0] adj_delta;
  logic signed [SEC_W+1:0] adj_sum;
  logic                    adj_ok;

  always_comb begin
    adj_delta = '0;
    case (mode_q)
      MODE_ADJS: begin
        case (ev)
          EV_LEFT:   adj_delta = -STEP_1S;
          EV_RIGHT:  adj_delta = STEP_1S;
          EV_LLEFT:  adj_delta = -STEP_10S;
          EV_LRIGHT: adj_delta = STEP_10S;
          default: ;
        endcase
      end
      MODE_ADJM: begin
        case (ev)
          EV_LEFT:   adj_delta = -STEP_1M;
          EV_RIGHT:  adj_delta = STEP_1M;
          EV_LLEFT:  adj_delta = -STEP_10M;
          EV_LRIGHT: adj_delta = STEP_10M;
          default: ;
        endcase
      end
      MODE_ADJH: begin
        case (ev)
          EV_LEFT:  adj_delta = -STEP_1H;
          EV_RIGHT: adj_delta = STEP_1H;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign adj_sum = $signed({2'b00, sec_q}) +
                   $signed({{(SEC_W+2-ADJ_W){adj_delta[ADJ_W-1]}}, adj_delta});
  assign adj_ok  = !adj_sum[SEC_W+1] && (adj_sum[SEC_W:0] <= {1'b0, max_sec_q});

  // ---------------------------------------------------------------------------
  // Next state and mode table
  // ---------------------------------------------------------------------------
  logic alarm_s, stored_s, sleep_s;
  logic [TMO_W-1:0] tmo_alarm;

  assign tmo_alarm = (tmo_limit_q > alarm_hold_q) ? (tmo_limit_q - alarm_hold_q) : '0;

  always_comb begin
    mode_d   = mode_q;
    sec_d    = sec_q;
    slot_d   = slot_q;
    lhold_d  = lhold_q;
    rhold_d  = rhold_q;
    tmo_d    = tmo_q;
    guard_d  = guard_q;
    alarm_s  = 1'b0;
    stored_s = 1'b0;

    if (mode_q == MODE_DOWN) begin
      // only a wake gets through
      if (op == OP_WAKE) begin
        mode_d  = MODE_INIT;
        guard_d = wake_ticks_q;
      end
    end else begin
      case (op)
        OP_SLOW: if (tmo_q != TMO_TOP) tmo_d = tmo_q + TMO_W'(1);
        OP_SEC:  if (counting && sec_q != '0) sec_d = sec_q - SEC_W'(1);
        OP_POLL: begin
          if (guard_q != '0) begin
            guard_d = guard_q - GUARD_W'(1);
          end else if (tmo_fire) begin
            tmo_d = '0;
          end else begin
            lhold_d = lhold_n;
            if (mode_q != MODE_ALARM) rhold_d = rhold_n;
            if (alarm_go) begin
              mode_d  = MODE_ALARM;
              sec_d   = preset_rd;
              tmo_d   = tmo_alarm;
              alarm_s = 1'b1;
            end else if (any_press) begin
              tmo_d = '0;
            end
          end
        end
        default: ;
      endcase
    end

    if (ev != EV_NONE) begin
      unique case (mode_q)
        MODE_INIT: begin
          case (ev)
            EV_LEFT:  mode_d = MODE_COUNT;
            EV_RIGHT: begin
              slot_d = slot_next;
              sec_d  = preset_rd;
            end
            EV_BOTH:  mode_d = MODE_ADJS;
            EV_LLEFT: begin
              slot_d = '0;
              sec_d  = preset_rd;
            end
            EV_LRIGHT, EV_TIMEOUT: mode_d = MODE_DOWN;
            default: ;
          endcase
        end
        MODE_COUNT, MODE_WAIT: begin
          case (ev)
            EV_LEFT:    mode_d = (mode_q == MODE_COUNT) ? MODE_WAIT : MODE_COUNT;
            EV_RIGHT: begin
              mode_d = MODE_INIT;
              sec_d  = preset_rd;
            end
            EV_BOTH:    mode_d = MODE_ADJS;
            EV_LRIGHT:  mode_d = MODE_DOWN;
            EV_TIMEOUT: mode_d = (mode_q == MODE_COUNT) ? MODE_SAVE : MODE_DOWN;
            default: ;
          endcase
        end
        MODE_ADJS, MODE_ADJM: begin
          case (ev)
            EV_LEFT, EV_RIGHT, EV_LLEFT, EV_LRIGHT: begin
              if (adj_ok) sec_d = adj_sum[SEC_W-1:0];
            end
            EV_BOTH:    mode_d = (mode_q == MODE_ADJS) ? MODE_ADJM : MODE_ADJH;
            EV_TIMEOUT: mode_d = MODE_DOWN;
            default: ;
          endcase
        end
        MODE_ADJH: begin
          case (ev)
            EV_LEFT, EV_RIGHT: begin
              if (adj_ok) sec_d = adj_sum[SEC_W-1:0];
            end
            EV_BOTH: begin
              stored_s = 1'b1;
              mode_d   = MODE_INIT;
            end
            EV_LLEFT:              mode_d = MODE_COUNT;
            EV_LRIGHT, EV_TIMEOUT: mode_d = MODE_DOWN;
            default: ;
          endcase
        end
        MODE_ALARM: begin
          case (ev)
            EV_LEFT: begin
              mode_d = MODE_INIT;
              sec_d  = preset_rd;
            end
            EV_LRIGHT, EV_TIMEOUT: mode_d = MODE_DOWN;
            default: ;
          endcase
        end
        MODE_SAVE: begin
          if (ev == EV_LEFT) mode_d = MODE_COUNT;
        end
        default: ;
      endcase
    end
  end

  // events only fire outside power down, so any step into down is a new entry
  assign sleep_s = (ev != EV_NONE) && (mode_d == MODE_DOWN);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_INIT;
      sec_q   <= '0;
      slot_q  <= '0;
      lhold_q <= '0;
      rhold_q <= '0;
      tmo_q   <= '0;
      guard_q <= WAKE_GUARD_RST;
      for (int i = 0; i < PRESET_SLOTS; i++) store_q[i] <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      sec_q   <= sec_d;
      slot_q  <= slot_d;
      lhold_q <= lhold_d;
      rhold_q <= rhold_d;
      tmo_q   <= tmo_d;
      guard_q <= guard_d;
      if (stored_s) store_q[cur_idx] <= sec_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  logic [MODE_W-1:0] res_mode_q;
  logic [SEC_W-1:0]  res_sec_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [EV_W-1:0]   res_ev_q;
  logic              res_alarm_q, res_stored_q, res_sleep_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_mode_q   <= mode_code(mode_d);
      res_sec_q    <= sec_d;
      res_slot_q   <= slot_d;
      res_ev_q     <= ev;
      res_alarm_q  <= alarm_s;
      res_stored_q <= stored_s;
      res_sleep_q  <= sleep_s;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.mode           = res_mode_q;
  assign out_ch.seconds_left   = res_sec_q;
  assign out_ch.preset_index   = res_slot_q;
  assign out_ch.event_code     = res_ev_q;
  assign out_ch.alarm_started  = res_alarm_q;
  assign out_ch.preset_written = res_stored_q;
  assign out_ch.sleep_request  = res_sleep_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_sleep_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ch.sleep_request |-> out_ch.mode == mode_code(MODE_DOWN))
    else $error("sleep request without power down mode");

  a_alarm_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ch.alarm_started |->
      out_ch.mode == mode_code(MODE_ALARM) && out_ch.event_code == EV_NONE)
    else $error("alarm start with wrong mode or event");

  a_store_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ch.preset_written |->
      out_ch.mode == mode_code(MODE_INIT) && out_ch.event_code == EV_BOTH)
    else $error("preset store outside hour adjust exit");

  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> {1'b0, slot_q} < SLOTS_N)
    else $error("preset slot out of range");

endmodule

### rtl/ctbc_button.sv
module ctbc_button import ctbc_pkg::*; (
  input  logic              level_i,
  input  logic [HOLD_W-1:0] hold_i,
  input  btn_cfg_t          cfg_i,
  output btn_e              press_o,
  output logic [HOLD_W-1:0] hold_o
);

  logic [HOLD_W-1:0] base;

  // hold count restarts here after a long press
  assign base = (cfg_i.long_ticks > cfg_i.repeat_ticks) ?
                (cfg_i.long_ticks - cfg_i.repeat_ticks) : '0;

  always_comb begin
    press_o = BTN_NONE;
    hold_o  = hold_i;
    if (level_i) begin
      // released
      if (hold_i != '0 && hold_i < base) press_o = BTN_SHORT;
      hold_o = '0;
    end else if (hold_i < cfg_i.long_ticks) begin
      hold_o = hold_i + HOLD_W'(1);
    end else begin
      press_o = BTN_LONG;
      hold_o  = base;
    end
  end

endmodule

### tb/tb.sv
module tb;
  import ctbc_pkg::*;

  localparam int unsigned SLOTS = PRESET_SLOTS_DEF;

  // External mode codes as they appear on the result channel
  typedef enum logic [MODE_W-1:0] {
    MD_INIT  = 4'd0,
    MD_COUNT = 4'd1,
    MD_WAIT  = 4'd2,
    MD_ADJS  = 4'd3,
    MD_ADJM  = 4'd4,
    MD_ADJH  = 4'd5,
    MD_ALARM = 4'd6,
    MD_SAVE  = 4'd7,
    MD_DOWN  = 4'd8
  } mode_code_e;

  typedef struct {
    op_e  op;
    logic left_lvl;
    logic right_lvl;
  } tick_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SEC_W-1:0]  secs;
    logic [SLOT_W-1:0] slot;
    logic [EV_W-1:0]   ev;
    logic              alarm;
    logic              stored;
    logic              slept;
  } outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // TB-side drive registers; initialized so every DUT input is known at time 0
  logic                  drv_valid = 1'b0;
  op_e                   drv_op    = OP_POLL;
  logic                  drv_left  = 1'b1;
  logic                  drv_right = 1'b1;
  logic                  rcv_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  ctbc_in_if  in_ch ();
  ctbc_out_if out_ch ();
  ctbc_cfg_if cfg_ch ();

  assign in_ch.valid       = drv_valid;
  assign in_ch.opcode      = drv_op;
  assign in_ch.left_level  = drv_left;
  assign in_ch.right_level = drv_right;
  assign out_ch.ready      = rcv_ready;
  assign cfg_ch.valid      = cfg_valid;
  assign cfg_ch.index      = cfg_index;
  assign cfg_ch.data       = cfg_data;

  countdown_timer_button_controller #(.PRESET_SLOTS(SLOTS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Ticks waiting to be offered, and results the controller still owes us
  tick_t    tick_queue[$];
  outcome_t awaited[$];

  int   mismatch_count = 0;
  int   taken_items    = 0;
  logic in_taken       = 1'b0;
  logic cfg_taken      = 1'b0;

  // ---------------------------------------------------------------------------
  // Shadow of the controller: configuration and state
  // ---------------------------------------------------------------------------
  logic [SEC_W-1:0]   cfg_max_secs;
  logic [TMO_W-1:0]   cfg_tlim;
  logic [TMO_W-1:0]   cfg_ahold;
  logic [HOLD_W-1:0]  cfg_long;
  logic [HOLD_W-1:0]  cfg_rep;
  logic [GUARD_W-1:0] cfg_guard;

  mode_code_e         md;
  logic [SEC_W-1:0]   secs;
  logic [SLOT_W-1:0]  slot;
  logic [SEC_W-1:0]   presets [SLOTS];
  logic [HOLD_W-1:0]  hold_l;
  logic [HOLD_W-1:0]  hold_r;
  logic [TMO_W-1:0]   idle_ticks;
  logic [GUARD_W-1:0] guard;
  logic               stored_now;
  logic               slept_now;

  // Out-of-range slot pointer falls back to slot 0
  function automatic int unsigned slot_at();
    return (slot < SLOTS) ? int'(slot) : 0;
  endfunction

  function automatic void reload();
    secs = presets[slot_at()];
  endfunction

  // Turns one pin level into a press. Count rises while held; on reaching the
  // long threshold a long press fires and the count drops back so the next
  // long fires after repeat_ticks. A release below that base is a short press.
  function automatic btn_e sample_btn(bit is_right, logic level);
    logic [HOLD_W-1:0] h;
    logic [HOLD_W-1:0] base;
    btn_e              r;
    h    = is_right ? hold_r : hold_l;
    base = (cfg_long > cfg_rep) ? cfg_long - cfg_rep : '0;
    r    = BTN_NONE;
    if (level) begin
      if (h != 0 && h < base) r = BTN_SHORT;
      h = '0;
    end else if (h < cfg_long) begin
      h = h + 1'b1;
    end else begin
      h = base;
      r = BTN_LONG;
    end
    if (is_right) hold_r = h;
    else hold_l = h;
    return r;
  endfunction

  function automatic ev_e sort_presses(btn_e a, btn_e b);
    if (a == BTN_SHORT && b == BTN_SHORT) return EV_BOTH;
    if (a == BTN_LONG && b == BTN_LONG) return EV_BOTH;
    if (a == BTN_LONG) return EV_LLEFT;
    if (b == BTN_LONG) return EV_LRIGHT;
    if (a == BTN_SHORT) return EV_LEFT;
    if (b == BTN_SHORT) return EV_RIGHT;
    return EV_NONE;
  endfunction

  // Adjust step; a result outside 0..max_seconds leaves the value alone
  function automatic void nudge(int delta);
    int v;
    v = int'(secs) + delta;
    if (v >= 0 && v <= int'(cfg_max_secs)) secs = v[SEC_W-1:0];
  endfunction

  function automatic void run_table(ev_e ev);
    mode_code_e nxt;
    nxt = md;
    case (md)
      MD_INIT: begin
        if (ev == EV_LEFT) nxt = MD_COUNT;
        else if (ev == EV_RIGHT) begin
          slot = (int'(slot) + 1 >= SLOTS) ? '0 : slot + 1'b1;
          reload();
        end else if (ev == EV_BOTH) nxt = MD_ADJS;
        else if (ev == EV_LLEFT) begin
          slot = '0;
          reload();
        end else if (ev == EV_LRIGHT || ev == EV_TIMEOUT) nxt = MD_DOWN;
      end
      MD_COUNT, MD_WAIT: begin
        if (ev == EV_LEFT) nxt = (md == MD_COUNT) ? MD_WAIT : MD_COUNT;
        else if (ev == EV_RIGHT) begin
          nxt = MD_INIT;
          reload();
        end else if (ev == EV_BOTH) nxt = MD_ADJS;
        else if (ev == EV_LRIGHT) nxt = MD_DOWN;
        else if (ev == EV_TIMEOUT) nxt = (md == MD_COUNT) ? MD_SAVE : MD_DOWN;
      end
      MD_ADJS: begin
        if (ev == EV_LEFT) nudge(-1);
        else if (ev == EV_RIGHT) nudge(1);
        else if (ev == EV_BOTH) nxt = MD_ADJM;
        else if (ev == EV_LLEFT) nudge(-10);
        else if (ev == EV_LRIGHT) nudge(10);
        else if (ev == EV_TIMEOUT) nxt = MD_DOWN;
      end
      MD_ADJM: begin
        if (ev == EV_LEFT) nudge(-60);
        else if (ev == EV_RIGHT) nudge(60);
        else if (ev == EV_BOTH) nxt = MD_ADJH;
        else if (ev == EV_LLEFT) nudge(-600);
        else if (ev == EV_LRIGHT) nudge(600);
        else if (ev == EV_TIMEOUT) nxt = MD_DOWN;
      end
      MD_ADJH: begin
        if (ev == EV_LEFT) nudge(-3600);
        else if (ev == EV_RIGHT) nudge(3600);
        else if (ev == EV_BOTH) begin
          presets[slot_at()] = secs;
          stored_now = 1'b1;
          nxt = MD_INIT;
        end else if (ev == EV_LLEFT) nxt = MD_COUNT;
        else if (ev == EV_LRIGHT || ev == EV_TIMEOUT) nxt = MD_DOWN;
      end
      MD_ALARM: begin
        if (ev == EV_LEFT) begin
          nxt = MD_INIT;
          reload();
        end else if (ev == EV_LRIGHT || ev == EV_TIMEOUT) nxt = MD_DOWN;
      end
      MD_SAVE: begin
        if (ev == EV_LEFT) nxt = MD_COUNT;
      end
      default: ;
    endcase
    if (nxt == MD_DOWN && md != MD_DOWN) slept_now = 1'b1;
    md = nxt;
  endfunction

  // Expected result of one accepted tick; advances the shadow state
  function automatic outcome_t step_model(op_e op, logic lvl_l, logic lvl_r);
    outcome_t o;
    btn_e     a;
    btn_e     b;
    ev_e      ev;
    logic     alarm;
    ev         = EV_NONE;
    alarm      = 1'b0;
    stored_now = 1'b0;
    slept_now  = 1'b0;
    if (md == MD_DOWN) begin
      // powered down: only a wake gets through
      if (op == OP_WAKE) begin
        md    = MD_INIT;
        guard = cfg_guard;
      end
    end else if (op == OP_SLOW) begin
      if (idle_ticks != TMO_TOP) idle_ticks = idle_ticks + 1'b1;
    end else if (op == OP_SEC) begin
      if ((md == MD_COUNT || md == MD_SAVE) && secs != 0) secs = secs - 1'b1;
    end else if (op == OP_POLL) begin
      if (guard != 0) begin
        guard = guard - 1'b1;
      end else if (idle_ticks > cfg_tlim) begin
        idle_ticks = '0;
        ev = EV_TIMEOUT;
        run_table(ev);
      end else begin
        a = sample_btn(1'b0, lvl_l);
        b = BTN_NONE;
        // right button is frozen while the alarm sounds
        if (md != MD_ALARM) b = sample_btn(1'b1, lvl_r);
        if (secs == 0 && (md == MD_COUNT || md == MD_SAVE)) begin
          md = MD_ALARM;
          reload();
          idle_ticks = (cfg_tlim > cfg_ahold) ? cfg_tlim - cfg_ahold : '0;
          alarm = 1'b1;
        end else if (a != BTN_NONE || b != BTN_NONE) begin
          idle_ticks = '0;
          ev = sort_presses(a, b);
          if (ev != EV_NONE) run_table(ev);
        end
      end
    end
    o.mode   = md;
    o.secs   = secs;
    o.slot   = slot;
    o.ev     = ev;
    o.alarm  = alarm;
    o.stored = stored_now;
    o.slept  = slept_now;
    return o;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: everything happens at the rising edge. Config transfers update
  // the shadow config, input transfers advance the shadow and queue the
  // expected result, output transfers are checked against the oldest one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    outcome_t want;
    if (!rst_ni) begin
      cfg_max_secs = MAX_SECONDS_RST;
      cfg_tlim     = TIMEOUT_LIMIT_RST;
      cfg_ahold    = ALARM_HOLD_RST;
      cfg_long     = LONG_TICKS_RST;
      cfg_rep      = REPEAT_TICKS_RST;
      cfg_guard    = WAKE_GUARD_RST;
      md           = MD_INIT;
      secs         = '0;
      slot         = '0;
      foreach (presets[i]) presets[i] = '0;
      hold_l       = '0;
      hold_r       = '0;
      idle_ticks   = '0;
      guard        = WAKE_GUARD_RST;
      in_taken  <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken  <= in_ch.valid && in_ch.ready;
      cfg_taken <= cfg_ch.valid && cfg_ch.ready;

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_e'(cfg_ch.index))
          CFG_MAX_SECONDS:   cfg_max_secs = cfg_ch.data;
          CFG_TIMEOUT_LIMIT: cfg_tlim     = cfg_ch.data[TMO_W-1:0];
          CFG_ALARM_HOLD:    cfg_ahold    = cfg_ch.data[TMO_W-1:0];
          CFG_LONG_TICKS:    cfg_long     = cfg_ch.data[HOLD_W-1:0];
          CFG_REPEAT_TICKS:  cfg_rep      = cfg_ch.data[HOLD_W-1:0];
          CFG_WAKE_GUARD:    cfg_guard    = cfg_ch.data[GUARD_W-1:0];
          default: ;
        endcase
      end

      // check before queuing: a tick taken this edge cannot have its result out yet
      if (out_ch.valid && out_ch.ready) begin
        if (awaited.size() == 0) begin
          $display("%0t unexpected result: expected none, actual mode %0d seconds %0d",
                   $time, out_ch.mode, out_ch.seconds_left);
          mismatch_count++;
        end else begin
          want = awaited.pop_front();
          check_field("mode", 32'(want.mode), 32'(out_ch.mode));
          check_field("seconds_left", 32'(want.secs), 32'(out_ch.seconds_left));
          check_field("preset_index", 32'(want.slot), 32'(out_ch.preset_index));
          check_field("event_code", 32'(want.ev), 32'(out_ch.event_code));
          check_field("alarm_started", 32'(want.alarm), 32'(out_ch.alarm_started));
          check_field("preset_written", 32'(want.stored), 32'(out_ch.preset_written));
          check_field("sleep_request", 32'(want.slept), 32'(out_ch.sleep_request));
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        awaited.push_back(step_model(op_e'(in_ch.opcode), in_ch.left_level,
                                     in_ch.right_level));
        void'(tick_queue.pop_front());
        taken_items++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tick driver: bursts of random length separated by random gaps. Once valid
  // is up it stays up until the transfer happens.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (drv_valid && !in_taken) begin
        // offer stands until taken
      end else if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        drv_valid <= 1'b0;
      end else if (tick_queue.size() == 0) begin
        drv_valid <= 1'b0;
      end else begin
        drv_valid <= 1'b1;
        drv_op    <= tick_queue[0].op;
        drv_left  <= tick_queue[0].left_lvl;
        drv_right <= tick_queue[0].right_lvl;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: randomly chosen spells of choppy or steady ready, plus one
  // long hold-off mid-run so the output register fills and input backs up.
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  int   spell      = 0;
  logic choppy     = 1'b0;
  logic held_once  = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rcv_ready  <= 1'b0;
      end else if (!held_once && taken_items >= 400 && tick_queue.size() > 20) begin
        held_once  <= 1'b1;
        stall_left <= 80;
        rcv_ready  <= 1'b0;
      end else begin
        if (spell == 0) begin
          spell  <= $urandom_range(1, 40);
          choppy <= ($urandom_range(0, 2) != 0);
        end else begin
          spell <= spell - 1;
        end
        rcv_ready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(op_e op, logic lv, logic rv);
    tick_queue.push_back('{op, lv, rv});
  endtask

  // Hold pins at the given levels for n polls, then release both. Now and
  // then a slow or second tick lands in the middle of the hold.
  task automatic hold_press(int n, logic lv, logic rv);
    for (int i = 0; i < n; i++) begin
      push_item(OP_POLL, lv, rv);
      if ($urandom_range(0, 11) == 0)
        push_item($urandom_range(0, 1) ? OP_SLOW : OP_SEC, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end
    push_item(OP_POLL, 1'b1, 1'b1);
  endtask

  task automatic push_run(op_e op, int n);
    for (int i = 0; i < n; i++) push_item(op, 1'b1, 1'b1);
  endtask

  // One random user gesture, sized from the live press thresholds.
  // Pins are active low: which = 0 left, 1 right, 2 both.
  task automatic add_gesture();
    int   kind;
    int   base;
    int   which;
    logic lv;
    logic rv;
    kind  = $urandom_range(0, 99);
    base  = (cfg_long > cfg_rep) ? int'(cfg_long) - int'(cfg_rep) : 0;
    which = $urandom_range(0, 2);
    lv    = (which == 1);
    rv    = (which == 0);
    if (kind < 30) begin
      hold_press((base > 1) ? $urandom_range(1, base - 1) : 1, lv, rv);
    end else if (kind < 45) begin
      hold_press(int'(cfg_long) + $urandom_range(0, 2 * cfg_rep + 1), lv, rv);
    end else if (kind < 57) begin
      push_run(OP_SEC, $urandom_range(1, 40));
    end else if (kind < 65) begin
      push_run(OP_SLOW, $urandom_range(1, int'(cfg_tlim) + 2));
    end else if (kind < 73) begin
      push_run(OP_POLL, $urandom_range(1, 4));
    end else if (kind < 80) begin
      // wake, then enough idle polls to work through the guard most times
      push_item(OP_WAKE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      push_run(OP_POLL, $urandom_range(0, 8));
    end else begin
      repeat ($urandom_range(1, 4))
        push_item(op_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end
  endtask

  task automatic queue_random(int count);
    while (tick_queue.size() < count) add_gesture();
  endtask

  // Wait until every tick is taken and every result checked
  task automatic drain();
    while (tick_queue.size() != 0 || awaited.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    while (!cfg_taken) @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(int ms, int tl, int ah, int lp, int rp, int wg);
    write_reg(CFG_MAX_SECONDS, CFG_DATA_W'(ms));
    write_reg(CFG_TIMEOUT_LIMIT, CFG_DATA_W'(tl));
    write_reg(CFG_ALARM_HOLD, CFG_DATA_W'(ah));
    write_reg(CFG_LONG_TICKS, CFG_DATA_W'(lp));
    write_reg(CFG_REPEAT_TICKS, CFG_DATA_W'(rp));
    write_reg(CFG_WAKE_GUARD, CFG_DATA_W'(wg));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed opening under reset config, then random
  // phases under several settings. Config changes only with nothing in flight,
  // which also gives the sender a full pause between phases.
  // ---------------------------------------------------------------------------
  initial begin
    int tl_r;
    int ah_r;
    int lp_r;
    int rp_r;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wake outside power down is dropped; slow/second ticks in init
    push_item(OP_WAKE, 1'b0, 1'b0);
    push_item(OP_SLOW, 1'b1, 1'b1);
    push_item(OP_SEC, 1'b0, 1'b1);
    // Seven polls swallowed by the post-reset wake guard, all level mixes
    push_item(OP_POLL, 1'b0, 1'b0);
    push_item(OP_POLL, 1'b0, 1'b1);
    push_item(OP_POLL, 1'b1, 1'b0);
    push_item(OP_POLL, 1'b1, 1'b1);
    push_item(OP_POLL, 1'b0, 1'b0);
    push_item(OP_POLL, 1'b1, 1'b1);
    push_item(OP_POLL, 1'b1, 1'b1);
    // Short left: init -> count; seconds are zero so next poll starts alarm
    push_item(OP_POLL, 1'b0, 1'b1);
    push_item(OP_POLL, 1'b1, 1'b1);
    push_item(OP_POLL, 1'b1, 1'b1);
    // In alarm the right pin is not sampled; short left returns to init
    push_item(OP_POLL, 1'b1, 1'b0);
    push_item(OP_POLL, 1'b0, 1'b0);
    push_item(OP_POLL, 1'b1, 1'b1);
    // Short right: next preset slot
    push_item(OP_POLL, 1'b1, 1'b0);
    push_item(OP_POLL, 1'b1, 1'b1);
    // Both short: adjust seconds; then right short adds one second
    push_item(OP_POLL, 1'b0, 1'b0);
    push_item(OP_POLL, 1'b1, 1'b1);
    push_item(OP_POLL, 1'b1, 1'b0);
    push_item(OP_POLL, 1'b1, 1'b1);
    // Second tick does not count down while adjusting
    push_item(OP_SEC, 1'b1, 1'b1);
    queue_random(170);
    drain();

    // Fastest presses, timeout on the smallest idle count, no wake guard
    apply_setting(16'hFFFF, 1, 0, 2, 1, 0);
    queue_random(160);
    drain();

    // Slowest presses, largest timeout (reaches saturation), max_seconds zero
    apply_setting(0, 126, 125, 63, 62, 7);
    queue_random(160);
    drain();

    apply_setting(600, 12, 5, 6, 2, 2);
    queue_random(160);
    drain();

    apply_setting(4000, 30, 29, 10, 3, 1);
    queue_random(160);
    drain();

    // Random legal setting
    tl_r = $urandom_range(2, 40);
    ah_r = $urandom_range(0, tl_r - 1);
    lp_r = $urandom_range(4, 20);
    rp_r = $urandom_range(1, lp_r - 1);
    apply_setting($urandom_range(100, 9000), tl_r, ah_r, lp_r, rp_r, $urandom_range(0, 7));
    queue_random(160);
    drain();

    apply_setting(35999, 20, 10, 8, 4, 3);
    queue_random(160);
    drain();

    // Quiet tail: anything still coming out now is an extra result
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #600000;
    $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
rtl/ctbc_pkg.sv
rtl/ctbc_if.sv
rtl/ctbc_button.sv
rtl/countdown_timer_button_controller.sv
tb/tb.sv
